// ===== design/sitda_pkg.sv =====
// shared constants and types for the signed integer to decimal ascii converter
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [MAX_DIGITS-1:0] bcd_t;

    typedef struct packed {
        logic load;
        logic step;
    } dabble_ctrl_t;

endpackage

// ===== design/sitda_dabble.sv =====
// shift-and-add-3 unit: one binary bit moves into the bcd digits per step
module sitda_dabble
    import sitda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dabble_ctrl_t        ctrl,
    input  logic [VALUE_W-1:0]  magnitude,
    output bcd_t                digits
);

    logic [VALUE_W-1:0] bin_reg;
    logic [VALUE_W-1:0] bin_next;
    bcd_t               bcd_reg;
    bcd_t               bcd_next;
    bcd_t               adj;
    logic [BCD_W-1:0]   adj_flat;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    assign adj_flat = adj;

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = magnitude;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {adj_flat[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
            bcd_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign digits = bcd_reg;

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// top level: sequencer, digit scan and output register of the decimal text converter
//
// Takes one signed 32-bit value per input beat and sends its decimal text,
// most significant character first, one character per output beat, with
// tlast on the final one; negative values get a leading '-', zero gives a
// single '0'. The magnitude goes through a shift-and-add-3 unit one bit per
// cycle once the value is accepted; a scan then finds the top digit, and
// the optional sign and the digits, 1 to 11 characters, each wait for a free
// output register. The input is not ready again until the last character
// has been loaded into the output register.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // value
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_tdata,   // character
    output logic                m_tlast
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [CHAR_W-1:0]    char_reg;
    logic [CHAR_W-1:0]    char_next;
    logic                 last_reg;
    logic                 last_next;

    dabble_ctrl_t         ctrl;
    logic [VALUE_W-1:0]   magnitude;
    bcd_t                 digits;
    logic [IDX_W-1:0]     top_idx;
    logic                 accept;
    logic                 out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign magnitude = s_tdata[VALUE_W-1] ? (~s_tdata + 32'd1) : s_tdata;

    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == S_CONV);

    sitda_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .magnitude (magnitude),
        .digits    (digits)
    );

    // highest nonzero digit, zero value keeps one digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (digits[i] != '0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        neg_next      = neg_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = s_tdata[VALUE_W-1];
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                idx_next   = top_idx;
                state_next = neg_reg ? S_SIGN : S_DIGIT;
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    char_next     = ASCII_MINUS;
                    last_next     = 1'b0;
                    state_next    = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    char_next     = ASCII_ZERO + {4'b0000, digits[idx_reg]};
                    last_next     = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            neg_reg      <= neg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule
